/* rtl/cau_pkg.sv */
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_DZERO = 2'd2
  } status_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned DEN_W  = 64;
  localparam int unsigned REM_W  = DEN_W + Q_W;

  typedef struct packed {
    logic              is_div;
    logic              dzero;
    logic              sat;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [REM_W-1:0]  dsh;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [Q_W-1:0]    q_re;
    logic [Q_W-1:0]    q_im;
  } cau_item_t;

endpackage

/* rtl/cau_div_step.sv */
module cau_div_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  cau_pkg::cau_item_t in_item,
  output logic              out_valid,
  output cau_pkg::cau_item_t out_item
);
  import cau_pkg::*;

  logic      valid_r;
  cau_item_t item_r;
  cau_item_t item_nxt;

  always_comb begin
    item_nxt = in_item;
    if (in_item.rem_re >= in_item.dsh) begin
      item_nxt.rem_re = in_item.rem_re - in_item.dsh;
      item_nxt.q_re   = {in_item.q_re[Q_W-2:0], 1'b1};
    end else begin
      item_nxt.q_re   = {in_item.q_re[Q_W-2:0], 1'b0};
    end
    if (in_item.rem_im >= in_item.dsh) begin
      item_nxt.rem_im = in_item.rem_im - in_item.dsh;
      item_nxt.q_im   = {in_item.q_im[Q_W-2:0], 1'b1};
    end else begin
      item_nxt.q_im   = {in_item.q_im[Q_W-2:0], 1'b0};
    end
    item_nxt.dsh = in_item.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit on signed fixed-point operands with FRAC_BITS fraction bits.
// A request arrives on the in_ channel: the operation code in in_tuser and the two
// complex operands in in_tdata. Each request gives exactly one result on the out_
// channel: the real and imaginary parts in out_tdata and the status in out_tuser.
// Add and subtract work part by part, multiply keeps full-width products and drops
// the low fraction bits, and divide uses the conjugate over the squared magnitude,
// truncating toward zero. Parts saturate to 32-bit signed and flag this in the
// status; a divide by zero returns zero with its own status code.
// Every request, whatever its operation, takes the same path: an input register, a
// product stage, a sum stage, a divide set-up stage, 32 restoring divide steps of one
// quotient bit each and an output register, 37 register stages in all. The input
// register loads at the accepting edge, and results leave in request order.
// A new request is accepted every cycle while out_tready is high. Each stage has
// its own valid bit, and when the receiver holds out_tready low the pipeline
// closes up its bubbles before in_tready falls; nothing is dropped or repeated.
// Reset clears the valid bits only.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // a_re, a_im, b_re, b_im
  input  logic [1:0]   in_tuser,  // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // result_re, result_im
  output logic [1:0]   out_tuser  // status
);
  import cau_pkg::*;

  localparam int unsigned NSTEP = Q_W;

  function automatic logic [DATA_W:0] sat65(input logic signed [64:0] x);
    logic signed [64:0] hi_lim;
    logic signed [64:0] lo_lim;
    hi_lim = 65'sh0_7FFF_FFFF;
    lo_lim = -65'sh0_8000_0000;
    if (x > hi_lim) begin
      sat65 = {1'b1, 32'h7FFF_FFFF};
    end else if (x < lo_lim) begin
      sat65 = {1'b1, 32'h8000_0000};
    end else begin
      sat65 = {1'b0, x[DATA_W-1:0]};
    end
  endfunction

  // Input register.
  logic                     v1_r;
  op_t                      op1_r;
  logic signed [DATA_W-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  // Products.
  logic                     v2_r;
  op_t                      op2_r;
  logic                     dz2_r;
  logic signed [63:0]       p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r, p_brbr_r, p_bibi_r;
  logic signed [DATA_W:0]   s_re2_r, s_im2_r;
  // Sums and divide set-up.
  logic                     v3_r, v4_r;
  cau_item_t                it3_r, it3_nxt, it4_r, it4_nxt;
  // Divide steps.
  logic      [NSTEP-1:0]    sv;
  logic      [NSTEP-1:0]    srdy;
  cau_item_t                sit [NSTEP];
  // Output register.
  logic                     vf_r;
  logic [DATA_W-1:0]        ore_r, oim_r, ore_nxt, oim_nxt;
  status_t                  ost_r, ost_nxt;

  logic rdy1, rdy2, rdy3, rdy4, rdyf;

  assign rdyf      = !vf_r || out_tready;
  assign rdy4      = !v4_r || srdy[0];
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyf) vf_r <= sv[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r <= op_t'(in_tuser);
      ar1_r <= in_tdata[31:0];
      ai1_r <= in_tdata[63:32];
      br1_r <= in_tdata[95:64];
      bi1_r <= in_tdata[127:96];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      op2_r    <= op1_r;
      dz2_r    <= (br1_r == '0) && (bi1_r == '0);
      p_arbr_r <= ar1_r * br1_r;
      p_aibi_r <= ai1_r * bi1_r;
      p_arbi_r <= ar1_r * bi1_r;
      p_aibr_r <= ai1_r * br1_r;
      p_brbr_r <= br1_r * br1_r;
      p_bibi_r <= bi1_r * bi1_r;
      if (op1_r == OP_SUB) begin
        s_re2_r <= {ar1_r[DATA_W-1], ar1_r} - {br1_r[DATA_W-1], br1_r};
        s_im2_r <= {ai1_r[DATA_W-1], ai1_r} - {bi1_r[DATA_W-1], bi1_r};
      end else begin
        s_re2_r <= {ar1_r[DATA_W-1], ar1_r} + {br1_r[DATA_W-1], br1_r};
        s_im2_r <= {ai1_r[DATA_W-1], ai1_r} + {bi1_r[DATA_W-1], bi1_r};
      end
    end
  end

  always_comb begin
    logic signed [64:0] mre, mim, nre, nim, xre, xim;
    logic [DATA_W:0]    sre, sim;
    logic [64:0]        mag_re, mag_im;
    logic [DEN_W-1:0]   den;
    mre = $signed({p_arbr_r[63], p_arbr_r}) - $signed({p_aibi_r[63], p_aibi_r});
    mim = $signed({p_arbi_r[63], p_arbi_r}) + $signed({p_aibr_r[63], p_aibr_r});
    nre = $signed({p_arbr_r[63], p_arbr_r}) + $signed({p_aibi_r[63], p_aibi_r});
    nim = $signed({p_aibr_r[63], p_aibr_r}) - $signed({p_arbi_r[63], p_arbi_r});
    den = $unsigned(p_brbr_r) + $unsigned(p_bibi_r);
    if (op2_r == OP_MUL) begin
      xre = mre >>> FRAC_BITS;
      xim = mim >>> FRAC_BITS;
    end else begin
      xre = {{32{s_re2_r[DATA_W]}}, s_re2_r};
      xim = {{32{s_im2_r[DATA_W]}}, s_im2_r};
    end
    sre    = sat65(xre);
    sim    = sat65(xim);
    mag_re = nre[64] ? $unsigned(-nre) : $unsigned(nre);
    mag_im = nim[64] ? $unsigned(-nim) : $unsigned(nim);
    it3_nxt        = '0;
    it3_nxt.is_div = (op2_r == OP_DIV);
    it3_nxt.dzero  = dz2_r;
    it3_nxt.sat    = sre[DATA_W] || sim[DATA_W];
    it3_nxt.re     = sre[DATA_W-1:0];
    it3_nxt.im     = sim[DATA_W-1:0];
    it3_nxt.dsh    = {{(REM_W-DEN_W){1'b0}}, den};
    it3_nxt.neg_re = nre[64];
    it3_nxt.neg_im = nim[64];
    it3_nxt.rem_re = {{(REM_W-65){1'b0}}, mag_re};
    it3_nxt.rem_im = {{(REM_W-65){1'b0}}, mag_im};
  end

  always_comb begin
    logic [REM_W-1:0] d32;
    d32            = it3_r.dsh << Q_W;
    it4_nxt        = it3_r;
    it4_nxt.rem_re = it3_r.rem_re << FRAC_BITS;
    it4_nxt.rem_im = it3_r.rem_im << FRAC_BITS;
    it4_nxt.ovf_re = it4_nxt.rem_re >= d32;
    it4_nxt.ovf_im = it4_nxt.rem_im >= d32;
    it4_nxt.dsh    = it3_r.dsh << (Q_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rdy3) it3_r <= it3_nxt;
    if (rdy4) it4_r <= it4_nxt;
  end

  genvar k;
  generate
    for (k = 0; k < NSTEP; k++) begin : g_step
      if (k == NSTEP - 1) begin : g_last
        assign srdy[k] = !sv[k] || rdyf;
      end else begin : g_mid
        assign srdy[k] = !sv[k] || srdy[k+1];
      end
      if (k == 0) begin : g_first
        cau_div_step u_step (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (srdy[k]),
          .in_valid (v4_r),
          .in_item  (it4_r),
          .out_valid(sv[k]),
          .out_item (sit[k])
        );
      end else begin : g_next
        cau_div_step u_step (
          .clk      (clk),
          .rst_n    (rst_n),
          .adv      (srdy[k]),
          .in_valid (sv[k-1]),
          .in_item  (sit[k-1]),
          .out_valid(sv[k]),
          .out_item (sit[k])
        );
      end
    end
  endgenerate

  always_comb begin
    cau_item_t it;
    logic      sat_re, sat_im;
    it     = sit[NSTEP-1];
    sat_re = 1'b0;
    sat_im = 1'b0;
    if (it.neg_re) begin
      sat_re  = it.ovf_re || (it.q_re[Q_W-1] && (|it.q_re[Q_W-2:0]));
      ore_nxt = sat_re ? 32'h8000_0000 : 32'd0 - it.q_re;
    end else begin
      sat_re  = it.ovf_re || it.q_re[Q_W-1];
      ore_nxt = sat_re ? 32'h7FFF_FFFF : it.q_re;
    end
    if (it.neg_im) begin
      sat_im  = it.ovf_im || (it.q_im[Q_W-1] && (|it.q_im[Q_W-2:0]));
      oim_nxt = sat_im ? 32'h8000_0000 : 32'd0 - it.q_im;
    end else begin
      sat_im  = it.ovf_im || it.q_im[Q_W-1];
      oim_nxt = sat_im ? 32'h7FFF_FFFF : it.q_im;
    end
    ost_nxt = (sat_re || sat_im) ? ST_SAT : ST_OK;
    if (!it.is_div) begin
      ore_nxt = it.re;
      oim_nxt = it.im;
      ost_nxt = it.sat ? ST_SAT : ST_OK;
    end else if (it.dzero) begin
      ore_nxt = '0;
      oim_nxt = '0;
      ost_nxt = ST_DZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyf) begin
      ore_r <= ore_nxt;
      oim_r <= oim_nxt;
      ost_r <= ost_nxt;
    end
  end

  assign out_tvalid = vf_r;
  assign out_tdata  = {oim_r, ore_r};
  assign out_tuser  = ost_r;

  a_dzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vf_r && ost_r == ST_DZERO) |-> (ore_r == '0 && oim_r == '0))
    else $error("Divide by zero result is not zero.");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (vf_r && ost_r == ST_SAT) |->
      (ore_r == 32'h7FFF_FFFF || ore_r == 32'h8000_0000 ||
       oim_r == 32'h7FFF_FFFF || oim_r == 32'h8000_0000))
    else $error("Saturated status without a part at a rail.");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("Accepted request did not enter the pipeline.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sv[NSTEP-1] && vf_r && !out_tready) |=> sv[NSTEP-1])
    else $error("Last divide step lost its request under a stall.");

endmodule
